[hw/rtl/lir_pkg.sv]
// Shared constants and types of the linear interpolation resampler.
package lir_pkg;

  // Phase counts in 1/OUT_RATE source frames; during a run it stays below OUT_RATE + 2^18
  localparam int unsigned PHASE_W = 19;
  localparam int unsigned RATE_W  = 18;
  localparam int unsigned SAMP_W  = 16;

  localparam logic [PHASE_W-1:0] OUT_RATE   = 19'd48000;
  localparam logic [PHASE_W-1:0] OUT_RATE_X2 = 19'd96000;
  localparam logic [RATE_W-1:0]  MIN_RATE   = 18'd8000;   // ceil(OUT_RATE / 6)
  localparam logic [RATE_W-1:0]  RATE_RESET = 18'd48000;

  // Divide by OUT_RATE: q0 = (x * RECIP) >> 32 is q or q - 1 for x below 2^32
  localparam logic [16:0] RECIP      = 17'd89478;   // floor(2^32 / 48000)
  localparam logic [15:0] DIVISOR_16 = 16'd48000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_D,
    S_MUL_R,
    S_MUL_Q,
    S_FIX,
    S_EMIT,
    S_MARK
  } lir_state_t;

endpackage

[hw/rtl/linear_interp_resampler_top.sv]
// Stereo linear interpolation resampler to a fixed 48 kHz output rate.
//
// Source frames (left, right, final flag) enter one word at a time and are
// resampled to 48000 Hz by linear interpolation between the previous and the
// current frame: each output sample is a + trunc((b - a) * phase / 48000), with
// phase counted in 1/48000 source frames and advanced by source_rate for every
// output. source_rate is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, which the block does not enforce; values
// below 8000 act as 8000, so one source frame yields at most six outputs
// (twelve for the final frame). The first frame is only stored. After the
// final frame, positions left at or after it repeat it unchanged; if the final
// frame yields nothing, a bare end marker (has_frame = 0) is given. Frames after
// the end are taken and dropped. out_tlast flags the last result of each input
// word. The block takes one input word at a time and is busy until it has
// finished the phase wrap after its last result. One shared 32x17 multiplier
// does the work: an interpolated result takes one phase check, four multiplier
// steps per channel and one output load, a repeated final-frame result one
// phase check and one output load, and each input word adds its accept and one
// phase-wrap check (none for the first frame); the final frame adds one closing
// check, and a bare end marker its load. Results wait in a one-word output
// register, so a stalled output stalls the sequencer only when a new result must be loaded.
module linear_interp_resampler_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: source_rate
  input  logic        cfg_we,
  input  logic [17:0] cfg_wdata,
  // source frames
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] left_in, [31:16] right_in
  input  logic        in_tlast,   // final_frame
  // resampled frames
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] left_out, [31:16] right_out
  output logic [1:0]  out_tuser,  // [0] has_frame, [1] stream_end
  output logic        out_tlast   // run_last
);

  lir_pkg::lir_state_t state_r, state_nxt;

  // control state
  logic [lir_pkg::PHASE_W-1:0] phase_r;
  logic [lir_pkg::PHASE_W-1:0] ph_inc_r;
  logic [lir_pkg::RATE_W-1:0]  rate_r;
  logic                        have_prev_r;
  logic                        finished_r;
  logic                        mode_interp_r;  // 1: between prev and cur, 0: repeat final frame
  logic                        emitted_r;      // current input word has produced a result
  logic                        ch_r;           // 0: left, 1: right
  logic                        out_valid_r;

  // payload
  logic signed [lir_pkg::SAMP_W-1:0] prev_l_r, prev_r_r;
  logic signed [lir_pkg::SAMP_W-1:0] cur_l_r, cur_r_r;
  logic signed [lir_pkg::SAMP_W-1:0] res_l_r, res_r_r;
  logic                              last_r;
  logic                              d_neg_r;
  logic [48:0]                       mul_r;
  logic [31:0]                       x_r;
  logic [15:0]                       q0_r;
  logic [31:0]                       out_data_r;
  logic [1:0]                        out_user_r;
  logic                              out_last_r;

  // combinational
  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        phase_lt;
  logic        more;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_p;
  logic signed [16:0] diff;
  logic [15:0] abs_d;
  logic [31:0] rem;
  logic [16:0] q_fix;
  logic signed [17:0] interp_val;
  logic signed [lir_pkg::SAMP_W-1:0] prev_ch;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign phase_lt = phase_r < lir_pkg::OUT_RATE;

  // Another result follows in this word: still inside the interval, or the
  // wrap leaves a repeat position behind the final frame.
  assign more = (ph_inc_r < lir_pkg::OUT_RATE) ||
                (mode_interp_r && last_r && (ph_inc_r < lir_pkg::OUT_RATE_X2));

  // channel difference and its magnitude
  assign prev_ch = ch_r ? prev_r_r : prev_l_r;
  assign diff    = ch_r ? (17'(cur_r_r) - 17'(prev_r_r)) : (17'(cur_l_r) - 17'(prev_l_r));
  assign abs_d   = diff[16] ? 16'(-diff) : diff[15:0];

  // shared multiplier
  assign mul_p = {17'd0, mul_a} * {32'd0, mul_b};

  // correction step of the reciprocal divide, then apply sign and offset
  assign rem        = x_r - mul_r[31:0];
  assign q_fix      = {1'b0, q0_r} + {16'd0, (rem >= {13'd0, lir_pkg::OUT_RATE})};
  assign interp_val = 18'(prev_ch) + (d_neg_r ? -18'(q_fix) : 18'(q_fix));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lir_pkg::S_IDLE: begin
        if (accept && !finished_r && (have_prev_r || in_tlast)) begin
          state_nxt = lir_pkg::S_CHECK;
        end
      end
      lir_pkg::S_CHECK: begin
        if (mode_interp_r) begin
          if (phase_lt) begin
            state_nxt = lir_pkg::S_MUL_D;
          end else if (!last_r) begin
            state_nxt = lir_pkg::S_IDLE;
          end
        end else if (phase_lt) begin
          state_nxt = lir_pkg::S_EMIT;
        end else if (emitted_r) begin
          state_nxt = lir_pkg::S_IDLE;
        end else begin
          state_nxt = lir_pkg::S_MARK;
        end
      end
      lir_pkg::S_MUL_D: state_nxt = lir_pkg::S_MUL_R;
      lir_pkg::S_MUL_R: state_nxt = lir_pkg::S_MUL_Q;
      lir_pkg::S_MUL_Q: state_nxt = lir_pkg::S_FIX;
      lir_pkg::S_FIX:   state_nxt = ch_r ? lir_pkg::S_EMIT : lir_pkg::S_MUL_D;
      lir_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = lir_pkg::S_CHECK;
        end
      end
      lir_pkg::S_MARK: begin
        if (out_free) begin
          state_nxt = lir_pkg::S_IDLE;
        end
      end
      default: state_nxt = lir_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      lir_pkg::S_IDLE: in_tready = 1'b1;
      lir_pkg::S_MUL_D: begin
        mul_a = {16'd0, abs_d};
        mul_b = {1'b0, phase_r[15:0]};
      end
      lir_pkg::S_MUL_R: begin
        mul_a = mul_r[31:0];
        mul_b = lir_pkg::RECIP;
      end
      lir_pkg::S_MUL_Q: begin
        mul_a = {16'd0, mul_r[47:32]};
        mul_b = {1'b0, lir_pkg::DIVISOR_16};
      end
      lir_pkg::S_EMIT: out_load = out_free;
      lir_pkg::S_MARK: out_load = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lir_pkg::S_IDLE;
      phase_r       <= '0;
      ph_inc_r      <= '0;
      rate_r        <= lir_pkg::RATE_RESET;
      have_prev_r   <= 1'b0;
      finished_r    <= 1'b0;
      mode_interp_r <= 1'b0;
      emitted_r     <= 1'b0;
      ch_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      prev_l_r      <= '0;
      prev_r_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        rate_r <= (cfg_wdata < lir_pkg::MIN_RATE) ? lir_pkg::MIN_RATE : cfg_wdata;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        lir_pkg::S_IDLE: begin
          if (accept && !finished_r) begin
            emitted_r     <= 1'b0;
            mode_interp_r <= have_prev_r;
            if (!have_prev_r) begin
              prev_l_r    <= in_tdata[15:0];
              prev_r_r    <= in_tdata[31:16];
              have_prev_r <= 1'b1;
            end
          end
        end
        lir_pkg::S_CHECK: begin
          if (phase_lt) begin
            ph_inc_r <= phase_r + {1'b0, rate_r};
            ch_r     <= 1'b0;
          end else if (mode_interp_r) begin
            // wrap to the current frame and make it the previous one
            phase_r  <= phase_r - lir_pkg::OUT_RATE;
            prev_l_r <= cur_l_r;
            prev_r_r <= cur_r_r;
            if (last_r) begin
              mode_interp_r <= 1'b0;
            end
          end else if (emitted_r) begin
            finished_r <= 1'b1;
          end
        end
        lir_pkg::S_FIX: ch_r <= 1'b1;
        lir_pkg::S_EMIT: begin
          if (out_free) begin
            phase_r   <= ph_inc_r;
            emitted_r <= 1'b1;
          end
        end
        lir_pkg::S_MARK: begin
          if (out_free) begin
            finished_r <= 1'b1;
          end
        end
        default: begin
          ch_r <= ch_r;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && state_r == lir_pkg::S_IDLE) begin
      cur_l_r <= in_tdata[15:0];
      cur_r_r <= in_tdata[31:16];
      last_r  <= in_tlast;
    end

    case (state_r)
      lir_pkg::S_CHECK: begin
        // repeat mode holds the final frame as the result
        if (!mode_interp_r) begin
          res_l_r <= cur_l_r;
          res_r_r <= cur_r_r;
        end
      end
      lir_pkg::S_MUL_D: begin
        d_neg_r <= diff[16];
        mul_r   <= mul_p;
      end
      lir_pkg::S_MUL_R: begin
        x_r   <= mul_r[31:0];
        mul_r <= mul_p;
      end
      lir_pkg::S_MUL_Q: begin
        q0_r  <= mul_r[47:32];
        mul_r <= mul_p;
      end
      lir_pkg::S_FIX: begin
        if (ch_r) begin
          res_r_r <= interp_val[15:0];
        end else begin
          res_l_r <= interp_val[15:0];
        end
      end
      default: begin
        mul_r <= mul_r;
      end
    endcase

    if (out_load) begin
      if (state_r == lir_pkg::S_MARK) begin
        out_data_r <= '0;
        out_user_r <= 2'b10;
        out_last_r <= 1'b1;
      end else begin
        out_data_r <= {res_r_r, res_l_r};
        out_user_r <= {last_r && !more, 1'b1};
        out_last_r <= !more;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // the end of the stream always closes a run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("stream_end without run_last");

  // a bare marker carries zero samples and ends the stream
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] && out_tlast && (out_tdata == 32'd0))
    else $error("malformed end marker");

  // nothing new comes out once the stream has ended and drained
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r && !out_valid_r |=> !out_valid_r)
    else $error("result after end of stream");

  // the stored phase fits the 18-bit state between words of a live stream
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lir_pkg::S_IDLE && !finished_r |-> !phase_r[lir_pkg::PHASE_W-1])
    else $error("phase out of range at idle");
`endif

endmodule
